FILE: rtl/lcd_page_transpose_unit_macros.svh
// assertion macros for the lcd page transpose rtl
`ifndef LCD_PAGE_TRANSPOSE_UNIT_MACROS_SVH
`define LCD_PAGE_TRANSPOSE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LCDPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LCDPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lcdpt_pkg.sv
// types and constants of the lcd page transpose unit
`default_nettype none

package lcdpt_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  localparam int ROWS_STORED = 7;
  localparam int WORD_W      = ROWS_STORED * 8;
  localparam int PAGE_FLD_W  = 4;

  localparam logic [2:0] ROW_LAST = 3'd7;

  localparam logic [7:0] START_LINE_RST = 8'd64;
  localparam logic [7:0] PAGE_BASE_RST  = 8'd176;
  localparam logic [7:0] COL_HIGH_RST   = 8'd16;
  localparam logic [7:0] COL_LOW_RST    = 8'd0;

  typedef enum logic [1:0] {
    CFG_START_LINE = 2'd0,
    CFG_PAGE_BASE  = 2'd1,
    CFG_COL_HIGH   = 2'd2,
    CFG_COL_LOW    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_START_LINE = 2'd0,
    CMD_PAGE_ADDR  = 2'd1,
    CMD_COL_HIGH   = 2'd2,
    CMD_COL_LOW    = 2'd3
  } cmd_sel_t;

  typedef struct packed {
    logic [7:0] start_line;
    logic [7:0] page_base;
    logic [7:0] col_high;
    logic [7:0] col_low;
  } cfg_t;

  typedef struct packed {
    logic                  is_data;
    logic [PAGE_FLD_W-1:0] page;
    logic [7:0]            pix;
    logic [WORD_W-1:0]     rows;
  } run_t;

endpackage

`default_nettype wire

FILE: rtl/lcdpt_if.sv
// valid/ready channel interfaces for pixel input and controller output
`default_nettype none

interface lcdpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface lcdpt_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output is_data, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input is_data, input out_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/lcdpt_ram.sv
// generic single-write single-read ram with registered read
`default_nettype none

module lcdpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcdpt_ingest.sv
// frame position, column buffer read-modify-write and run hand-off
`default_nettype none

module lcdpt_ingest #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  lcdpt_in_if.sink          in_ch,
  output logic              run_valid,
  input  wire logic         run_ready,
  output lcdpt_pkg::run_t   run
);
  import lcdpt_pkg::*;

  localparam int ROW_BYTES = COLUMNS / 8;
  localparam int CB_W      = ROW_BYTES > 1 ? $clog2(ROW_BYTES) : 1;
  localparam int PG_W      = PAGES > 1 ? $clog2(PAGES) : 1;

  logic [CB_W-1:0]   cb_r;
  logic [2:0]        row_r;
  logic [PG_W-1:0]   pg_r;

  logic              s1_valid_r;
  logic [2:0]        s1_row_r;
  logic [7:0]        s1_pix_r;
  logic [CB_W-1:0]   s1_cb_r;
  logic [PG_W-1:0]   s1_pg_r;
  logic              s1_first_r;
  logic              fwd_hit_r;
  logic [WORD_W-1:0] fwd_word_r;

  logic              s1_emit;
  logic              s1_go;
  logic              in_fire;
  logic              wr_en;
  logic [WORD_W-1:0] ram_rd_data;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] merged;

  assign s1_emit   = s1_first_r || (s1_row_r == ROW_LAST);
  assign s1_go     = s1_valid_r && (!s1_emit || run_ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign wr_en     = s1_go && (s1_row_r != ROW_LAST);

  // a write in the read cycle to the same entry is forwarded
  assign rd_word = fwd_hit_r ? fwd_word_r : ram_rd_data;

  always_comb begin
    merged = (s1_row_r == 3'd0) ? '0 : rd_word;
    for (int r = 0; r < ROWS_STORED; r++) begin
      if (s1_row_r == 3'(r)) begin
        merged[r*8 +: 8] = s1_pix_r;
      end
    end
  end

  lcdpt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROW_BYTES)
  ) u_col_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_cb_r),
    .wr_data (merged),
    .rd_en   (in_fire),
    .rd_addr (cb_r),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r       <= '0;
      row_r      <= '0;
      pg_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        if (cb_r == CB_W'(ROW_BYTES - 1)) begin
          cb_r <= '0;
          if (row_r == ROW_LAST) begin
            row_r <= '0;
            pg_r  <= (pg_r == PG_W'(PAGES - 1)) ? '0 : pg_r + 1'b1;
          end else begin
            row_r <= row_r + 3'd1;
          end
        end else begin
          cb_r <= cb_r + 1'b1;
        end
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row_r   <= row_r;
      s1_pix_r   <= in_ch.pixel_byte;
      s1_cb_r    <= cb_r;
      s1_pg_r    <= pg_r;
      s1_first_r <= (row_r == 3'd0) && (cb_r == '0);
      fwd_hit_r  <= wr_en && (s1_cb_r == cb_r);
      fwd_word_r <= merged;
    end
  end

  assign run_valid   = s1_valid_r && s1_emit;
  assign run.is_data = (s1_row_r == ROW_LAST);
  assign run.page    = PAGE_FLD_W'(s1_pg_r);
  assign run.pix     = s1_pix_r;
  assign run.rows    = merged;

endmodule

`default_nettype wire

FILE: rtl/lcdpt_emit.sv
// run sequencer: four page commands or eight column bytes per run
`default_nettype none

`include "lcd_page_transpose_unit_macros.svh"

module lcdpt_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lcdpt_pkg::cfg_t cfg,
  input  wire logic           run_valid,
  output logic                run_ready,
  input  wire lcdpt_pkg::run_t run,
  lcdpt_out_if.source         out_ch
);
  import lcdpt_pkg::*;

  logic                  em_valid_r;
  logic                  em_data_r;
  logic [2:0]            cnt_r;
  logic [WORD_W-1:0]     em_rows_r;
  logic [7:0]            em_pix_r;
  logic [PAGE_FLD_W-1:0] em_pg_r;

  logic       out_fire;
  logic       last;
  logic       run_take;
  logic [2:0] bit_idx;
  logic [7:0] col_byte;
  logic [7:0] cmd_byte;

  assign out_fire  = out_ch.valid && out_ch.ready;
  assign last      = em_data_r ? (cnt_r == 3'd7) : (cnt_r == {1'b0, CMD_COL_LOW});
  assign run_ready = !em_valid_r || (out_fire && last);
  assign run_take  = run_valid && run_ready;
  assign bit_idx   = ~cnt_r;

  // leftmost column first; bit k of the column byte is row k
  always_comb begin
    logic [7:0] lane;
    col_byte = '0;
    for (int k = 0; k < ROWS_STORED; k++) begin
      lane        = em_rows_r[k*8 +: 8];
      col_byte[k] = lane[bit_idx];
    end
    col_byte[7] = em_pix_r[bit_idx];
  end

  always_comb begin
    unique case (cmd_sel_t'(cnt_r[1:0]))
      CMD_START_LINE: cmd_byte = cfg.start_line;
      CMD_PAGE_ADDR:  cmd_byte = cfg.page_base + 8'(em_pg_r);
      CMD_COL_HIGH:   cmd_byte = cfg.col_high;
      CMD_COL_LOW:    cmd_byte = cfg.col_low;
      default:        cmd_byte = cfg.start_line;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (run_take) begin
        em_valid_r <= 1'b1;
        cnt_r      <= '0;
      end else if (out_fire) begin
        if (last) begin
          em_valid_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_take) begin
      em_data_r <= run.is_data;
      em_rows_r <= run.rows;
      em_pix_r  <= run.pix;
      em_pg_r   <= run.page;
    end
  end

  assign out_ch.valid       = em_valid_r;
  assign out_ch.is_data     = em_data_r;
  assign out_ch.out_byte    = em_data_r ? col_byte : cmd_byte;
  assign out_ch.last_of_run = last;

  `LCDPT_ASSERT_IMP(a_cmd_count, em_valid_r && !em_data_r, cnt_r[2] == 1'b0, "command run past four words")
  `LCDPT_ASSERT_NXT(a_run_continues, out_fire && !last, em_valid_r, "run dropped before its last word")
  `LCDPT_ASSERT_IMP(a_take_when_free, run_take, !em_valid_r || (out_fire && last), "run taken over a busy run")
  `LCDPT_ASSERT_NXT(a_run_starts, run_take, em_valid_r && (cnt_r == 3'd0), "new run not started at its first word")

endmodule

`default_nettype wire

FILE: rtl/lcd_page_transpose_unit.sv
// top level of the lcd page transpose unit: config registers, ingest and run emitter
// a run's first word is registered twice: in the ingest stage and then in the emitter
// throughput: one pixel word per cycle on rows 0 to 6; a row-7 word or a page's first word
// waits until the emitter has sent out its previous run, set by the single output port
// the column buffer is read, merged and written back in one pass per word, with forwarding
// reset: position, pipeline valid and config registers return to defaults; buffer is not cleared
`default_nettype none

module lcd_page_transpose_unit #(
  parameter int COLUMNS = lcdpt_pkg::COLUMNS_DEF,
  parameter int PAGES   = lcdpt_pkg::PAGES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  lcdpt_in_if.sink        in_ch,
  lcdpt_out_if.source     out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  import lcdpt_pkg::*;

  cfg_t cfg_r;
  logic run_valid;
  logic run_ready;
  run_t run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_line <= START_LINE_RST;
      cfg_r.page_base  <= PAGE_BASE_RST;
      cfg_r.col_high   <= COL_HIGH_RST;
      cfg_r.col_low    <= COL_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_LINE: cfg_r.start_line <= cfg_wdata;
        CFG_PAGE_BASE:  cfg_r.page_base  <= cfg_wdata;
        CFG_COL_HIGH:   cfg_r.col_high   <= cfg_wdata;
        CFG_COL_LOW:    cfg_r.col_low    <= cfg_wdata;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  lcdpt_ingest #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_ingest (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run       (run)
  );

  lcdpt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run       (run),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
